// ===== sv/assert_macros.svh =====
// Assertion macros used by the RTL file that checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property on the block clock, disabled while reset is asserted.
`define RSM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Same-cycle implication on the block clock, disabled while reset is asserted.
`define RSM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== sv/rsm_pkg.sv =====
// Shared constants for the random sample multiset block.
package rsm_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam int VAL_W  = 32;
    localparam int CMD_W  = 2;
    localparam int RW_W   = 31;
    localparam int STAT_W = 2;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

endpackage

// ===== sv/rsm_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
module rsm_ram #(
    parameter int WIDTH = rsm_pkg::VAL_W,
    parameter int DEPTH = rsm_pkg::CAPACITY_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/random_sample_multiset.sv =====
// Top level of the random sample multiset: a dense slot table with insert, remove and sample.
//
// The block keeps a multiset of signed 32-bit values in a slot RAM of CAPACITY entries plus an
// element count held in a register. One input transaction carries a command (insert, remove,
// sample) and produces exactly one result transaction. Insert appends the value at the slot
// indexed by the count and reports whether the value was absent before; it scans the occupied
// slots once, or not at all when the table is empty or full.
// Remove first checks the last occupied slot and then scans from slot zero for the lowest match;
// the last slot's value moves into the freed slot. Sample reduces the random word modulo the
// count with a restoring remainder unit that retires one bit per cycle, then reads the chosen
// slot. The single read port of the slot RAM sets the scan speed at one slot per cycle, and the
// 31 remainder steps set the sample time. The block works on one transaction at a time and
// stalls its input while busy; a finished result sits in an output register, so a new
// transaction is taken while the previous result still waits downstream. All slot writes happen
// at the end of a transaction and every read belongs to a later one, so no read ever overlaps a
// pending write to the same slot. Slots are never cleared: only data from occupied slots is
// ever used.
module random_sample_multiset #(
    parameter int CAPACITY = rsm_pkg::CAPACITY_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [rsm_pkg::CMD_W-1:0]         i_cmd,
    input  logic signed [rsm_pkg::VAL_W-1:0]  i_value,
    input  logic [rsm_pkg::RW_W-1:0]          i_random_word,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_answer_flag,
    output logic signed [rsm_pkg::VAL_W-1:0]  o_sample_value,
    output logic [rsm_pkg::STAT_W-1:0]        o_status
);

`include "assert_macros.svh"

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = $clog2(rsm_pkg::RW_W);

    // One-hot sequencer states.
    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_LASTCHK = 7'b0000010,
        S_SCAN    = 7'b0000100,
        S_DIV     = 7'b0001000,
        S_SREAD   = 7'b0010000,
        S_SDATA   = 7'b0100000,
        S_FIN     = 7'b1000000
    } t_state;

    t_state                        r_state, n_state;
    logic [CW-1:0]                 r_count, n_count;
    logic                          r_out_valid, n_out_valid;

    logic [rsm_pkg::CMD_W-1:0]     r_cmd, n_cmd;
    logic [rsm_pkg::VAL_W-1:0]     r_value, n_value;
    logic [rsm_pkg::RW_W-1:0]      r_dvd, n_dvd;
    logic [CW-1:0]                 r_rem, n_rem;
    logic [SW-1:0]                 r_bits, n_bits;
    logic [CW-1:0]                 r_iss, n_iss;
    logic                          r_cmp_vld, n_cmp_vld;
    logic [AW-1:0]                 r_cmp_idx, n_cmp_idx;
    logic [AW-1:0]                 r_pos, n_pos;
    logic [rsm_pkg::VAL_W-1:0]     r_last_val, n_last_val;
    logic                          r_flag, n_flag;
    logic [rsm_pkg::VAL_W-1:0]     r_sample, n_sample;
    logic [rsm_pkg::STAT_W-1:0]    r_status, n_status;
    logic                          r_out_flag, n_out_flag;
    logic [rsm_pkg::VAL_W-1:0]     r_out_sample, n_out_sample;
    logic [rsm_pkg::STAT_W-1:0]    r_out_status, n_out_status;

    logic [AW-1:0]                 last_idx;
    logic [AW-1:0]                 rd_addr;
    logic [rsm_pkg::VAL_W-1:0]     rd_data;
    logic                          mem_we;
    logic [AW-1:0]                 mem_waddr;
    logic [rsm_pkg::VAL_W-1:0]     mem_wdata;
    logic [CW:0]                   trial;
    logic                          trial_ge;
    logic                          hit;
    logic                          out_free;
    logic                          is_insert;
    logic                          commit_insert;
    logic                          commit_remove;

    // Slot table.
    rsm_ram #(
        .WIDTH (rsm_pkg::VAL_W),
        .DEPTH (CAPACITY)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // The last occupied slot; it wraps harmlessly when the table is empty.
    assign last_idx = AW'(r_count - CW'(1));

    // While idle the RAM keeps reading the last slot, so a remove can check it right away.
    always_comb begin
        unique case (r_state)
            S_SCAN:  rd_addr = r_iss[AW-1:0];
            S_SREAD: rd_addr = r_rem[AW-1:0];
            default: rd_addr = last_idx;
        endcase
    end

    // One restoring remainder step: bring in the next dividend bit and subtract if it fits.
    assign trial    = {r_rem, r_dvd[rsm_pkg::RW_W-1]};
    assign trial_ge = (trial >= {1'b0, r_count});

    assign hit      = r_cmp_vld && (rd_data == r_value);
    assign out_free = !r_out_valid || !i_out_stall;

    // Writes are committed together with the result, in the final state.
    assign is_insert     = (r_cmd == rsm_pkg::CMD_INSERT);
    assign commit_insert = is_insert && (r_status == rsm_pkg::ST_OK);
    assign commit_remove = (r_cmd == rsm_pkg::CMD_REMOVE) && r_flag;
    assign mem_we        = (r_state == S_FIN) && out_free
                           && (commit_insert || (commit_remove && (r_pos != last_idx)));
    assign mem_waddr     = is_insert ? r_count[AW-1:0] : r_pos;
    assign mem_wdata     = is_insert ? r_value : r_last_val;

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_out_valid  = r_out_valid;
        n_cmd        = r_cmd;
        n_value      = r_value;
        n_dvd        = r_dvd;
        n_rem        = r_rem;
        n_bits       = r_bits;
        n_iss        = r_iss;
        n_cmp_vld    = r_cmp_vld;
        n_cmp_idx    = r_cmp_idx;
        n_pos        = r_pos;
        n_last_val   = r_last_val;
        n_flag       = r_flag;
        n_sample     = r_sample;
        n_status     = r_status;
        n_out_flag   = r_out_flag;
        n_out_sample = r_out_sample;
        n_out_status = r_out_status;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd     = i_cmd;
                    n_value   = $unsigned(i_value);
                    n_dvd     = i_random_word;
                    n_rem     = '0;
                    n_bits    = SW'(rsm_pkg::RW_W - 1);
                    n_iss     = '0;
                    n_cmp_vld = 1'b0;
                    n_flag    = 1'b0;
                    n_sample  = '0;
                    n_status  = rsm_pkg::ST_OK;
                    unique case (i_cmd)
                        rsm_pkg::CMD_INSERT: begin
                            if (r_count == CW'(CAPACITY)) begin
                                n_status = rsm_pkg::ST_FULL;
                                n_state  = S_FIN;
                            end else if (r_count == '0) begin
                                n_flag  = 1'b1;
                                n_state = S_FIN;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        rsm_pkg::CMD_REMOVE: begin
                            n_state = (r_count == '0) ? S_FIN : S_LASTCHK;
                        end
                        rsm_pkg::CMD_SAMPLE: begin
                            if (r_count == '0) begin
                                n_status = rsm_pkg::ST_EMPTY;
                                n_state  = S_FIN;
                            end else begin
                                n_state = S_DIV;
                            end
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end
            S_LASTCHK: begin
                n_last_val = rd_data;
                if (rd_data == r_value) begin
                    n_flag  = 1'b1;
                    n_pos   = last_idx;
                    n_state = S_FIN;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (hit) begin
                    n_pos   = r_cmp_idx;
                    n_flag  = (r_cmd == rsm_pkg::CMD_REMOVE);
                    n_state = S_FIN;
                end else if ((r_iss == r_count) && !r_cmp_vld) begin
                    n_flag  = is_insert;
                    n_state = S_FIN;
                end else begin
                    n_cmp_vld = (r_iss < r_count);
                    n_cmp_idx = r_iss[AW-1:0];
                    if (r_iss < r_count) begin
                        n_iss = r_iss + CW'(1);
                    end
                end
            end
            S_DIV: begin
                n_rem  = trial_ge ? CW'(trial - {1'b0, r_count}) : CW'(trial);
                n_dvd  = r_dvd << 1;
                n_bits = r_bits - SW'(1);
                if (r_bits == '0) begin
                    n_state = S_SREAD;
                end
            end
            S_SREAD: begin
                n_state = S_SDATA;
            end
            S_SDATA: begin
                n_sample = rd_data;
                n_state  = S_FIN;
            end
            S_FIN: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_flag   = r_flag;
                    n_out_sample = r_sample;
                    n_out_status = r_status;
                    n_state      = S_IDLE;
                    if (commit_insert) begin
                        n_count = r_count + CW'(1);
                    end else if (commit_remove) begin
                        n_count = r_count - CW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Working and result payload.
    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_value      <= n_value;
        r_dvd        <= n_dvd;
        r_rem        <= n_rem;
        r_bits       <= n_bits;
        r_iss        <= n_iss;
        r_cmp_vld    <= n_cmp_vld;
        r_cmp_idx    <= n_cmp_idx;
        r_pos        <= n_pos;
        r_last_val   <= n_last_val;
        r_flag       <= n_flag;
        r_sample     <= n_sample;
        r_status     <= n_status;
        r_out_flag   <= n_out_flag;
        r_out_sample <= n_out_sample;
        r_out_status <= n_out_status;
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_answer_flag  = r_out_flag;
    assign o_sample_value = $signed(r_out_sample);
    assign o_status       = r_out_status;

    // The count never exceeds the table size.
    `RSM_ASSERT(a_count_bound, r_count <= CW'(CAPACITY), "element count above capacity")

    // The count moves by at most one, and only when a transaction finishes.
    `RSM_ASSERT_IMP(a_count_step, $past(i_rst_n) && (r_count != $past(r_count)),
        ($past(r_state) == S_FIN) && ((r_count == $past(r_count) + CW'(1))
        || (r_count == $past(r_count) - CW'(1))), "element count jumped")

    // A result appears only out of the final state.
    `RSM_ASSERT_IMP(a_out_from_fin, $past(i_rst_n) && $rose(r_out_valid),
        $past(r_state) == S_FIN, "result raised outside the final state")

    // The scan only compares occupied slots.
    `RSM_ASSERT_IMP(a_scan_in_range, (r_state == S_SCAN) && r_cmp_vld,
        r_cmp_idx < r_count, "scan compared a slot beyond the count")

endmodule
